@@ src/q24alu_pkg.sv @@
package q24alu_pkg;

   // fraction width of the raw operands
   localparam int FRAC_BITS_DEFAULT = 8;
   localparam int DATA_WIDTH = 32;

   // operation codes
   localparam logic [2:0] ACT_ADD    = 3'd0;
   localparam logic [2:0] ACT_SUB    = 3'd1;
   localparam logic [2:0] ACT_MUL    = 3'd2;
   localparam logic [2:0] ACT_DIV    = 3'd3;
   localparam logic [2:0] ACT_NEGATE = 3'd4;

   typedef struct packed {
      logic [2:0]         action;
      logic signed [31:0] operand_a;
      logic signed [31:0] operand_b;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result;
      logic               a_less_than_b;
      logic               a_equals_b;
      logic               divide_by_zero;
   } rsp_type;

endpackage

@@ src/q24_8_fixed_point_alu.sv @@
// Signed fixed-point ALU on raw two's complement operands (FRAC_BITS fraction bits).
// Request channel: drive req_data and raise start; the transaction is taken at
// the rising edge where start is high and busy is low. busy stays low, so a new
// transaction may be issued every cycle.
// Response channel: rsp_valid is high for exactly one cycle with rsp_data; the
// receiver must take it then, it cannot hold responses off.
// Operations: add, subtract, negate a, multiply and divide, with half-away-from-
// zero rounding on multiply and divide; divide by zero gives zero and a flag.
// Compare flags (a < b signed, a == b) come with every response.
// Every operation passes the decode register, the divider stages and the
// response register between the accepting edge and the edge that registers the
// response, so responses leave in issue order. Throughput: one transaction per
// cycle. The depth is set by the restoring divider, one quotient bit per stage
// over a dividend of FRAC_BITS + 33 bits; multiply rides alongside it.
// Reset clears all stage valid bits; transactions in flight are dropped and no
// response is strobed until new transactions come through.
module q24_8_fixed_point_alu #(
   parameter int FRAC_BITS = q24alu_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  q24alu_pkg::req_type req_data,
   output logic                rsp_valid,
   output q24alu_pkg::rsp_type rsp_data
);

   localparam int DW = q24alu_pkg::DATA_WIDTH;
   // dividend magnitude is |a| * 2^(FRAC_BITS+1)
   localparam int QW = DW + FRAC_BITS + 1;
   localparam int PW = 2 * DW;
   localparam int MSHIFT = FRAC_BITS - 1;

   typedef struct packed {
      logic              valid;
      logic [2:0]        action;
      logic [DW-1:0]     simple;
      logic              lt;
      logic              eq;
      logic              dz;
      logic              neg;
      logic [DW-1:0]     amag;
      logic [DW-1:0]     bmag;
      logic [DW-1:0]     rem;
      logic [QW-1:0]     dq;
      logic [PW-1:0]     prod;
   } stage_type;

   stage_type st_ff [0:QW];
   stage_type st_in [0:QW];

   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   q24alu_pkg::rsp_type  rsp_data_ff;
   q24alu_pkg::rsp_type  rsp_data_in;

   assign busy = 1'b0;

   // decode the request: magnitudes, signs, flags and the simple operations
   always_comb begin
      logic signed [DW-1:0] a_s;
      logic signed [DW-1:0] b_s;
      a_s = req_data.operand_a;
      b_s = req_data.operand_b;
      st_in[0] = '0;
      st_in[0].valid  = start & ~busy;
      st_in[0].action = req_data.action;
      st_in[0].lt     = (a_s < b_s);
      st_in[0].eq     = (a_s == b_s);
      st_in[0].dz     = (req_data.action == q24alu_pkg::ACT_DIV) && (b_s == '0);
      st_in[0].neg    = a_s[DW-1] ^ b_s[DW-1];
      st_in[0].amag   = a_s[DW-1] ? (~a_s + 1'b1) : a_s;
      st_in[0].bmag   = b_s[DW-1] ? (~b_s + 1'b1) : b_s;
      st_in[0].rem    = '0;
      st_in[0].dq     = {st_in[0].amag, {(FRAC_BITS+1){1'b0}}};
      st_in[0].prod   = '0;
      case (req_data.action)
         q24alu_pkg::ACT_ADD:    st_in[0].simple = a_s + b_s;
         q24alu_pkg::ACT_SUB:    st_in[0].simple = a_s - b_s;
         q24alu_pkg::ACT_NEGATE: st_in[0].simple = -a_s;
         default:                st_in[0].simple = '0;
      endcase
   end

   // hold the decoded request
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff[0].valid <= 1'b0;
      end else begin
         st_ff[0].valid <= st_in[0].valid;
      end
   end

   always_ff @(posedge clock) begin
      st_ff[0].action <= st_in[0].action;
      st_ff[0].simple <= st_in[0].simple;
      st_ff[0].lt     <= st_in[0].lt;
      st_ff[0].eq     <= st_in[0].eq;
      st_ff[0].dz     <= st_in[0].dz;
      st_ff[0].neg    <= st_in[0].neg;
      st_ff[0].amag   <= st_in[0].amag;
      st_ff[0].bmag   <= st_in[0].bmag;
      st_ff[0].rem    <= st_in[0].rem;
      st_ff[0].dq     <= st_in[0].dq;
      st_ff[0].prod   <= st_in[0].prod;
   end

   // divider stages: one restoring quotient bit per stage, product in the first
   for (genvar k = 1; k <= QW; k++) begin : g_stage
      always_comb begin
         logic [DW:0] trial;
         logic        ge;
         trial = {st_ff[k-1].rem, st_ff[k-1].dq[QW-1]};
         ge    = (trial >= {1'b0, st_ff[k-1].bmag});
         st_in[k]     = st_ff[k-1];
         st_in[k].rem = ge ? DW'(trial - {1'b0, st_ff[k-1].bmag}) : trial[DW-1:0];
         st_in[k].dq  = {st_ff[k-1].dq[QW-2:0], ge};
         if (k == 1) begin
            st_in[k].prod = PW'(st_ff[k-1].amag) * PW'(st_ff[k-1].bmag);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            st_ff[k].valid <= 1'b0;
         end else begin
            st_ff[k].valid <= st_in[k].valid;
         end
      end

      always_ff @(posedge clock) begin
         st_ff[k].action <= st_in[k].action;
         st_ff[k].simple <= st_in[k].simple;
         st_ff[k].lt     <= st_in[k].lt;
         st_ff[k].eq     <= st_in[k].eq;
         st_ff[k].dz     <= st_in[k].dz;
         st_ff[k].neg    <= st_in[k].neg;
         st_ff[k].amag   <= st_in[k].amag;
         st_ff[k].bmag   <= st_in[k].bmag;
         st_ff[k].rem    <= st_in[k].rem;
         st_ff[k].dq     <= st_in[k].dq;
         st_ff[k].prod   <= st_in[k].prod;
      end
   end

   // round half away from zero, restore the sign and select the result
   always_comb begin
      logic [PW-1:0] pmag;
      logic [DW:0]   mag;
      logic [DW+1:0] inc;
      logic [DW-1:0] rnd;
      pmag = st_ff[QW].prod >> MSHIFT;
      mag  = (st_ff[QW].action == q24alu_pkg::ACT_MUL) ? pmag[DW:0] : st_ff[QW].dq[DW:0];
      inc  = {1'b0, mag} + 1'b1;
      rnd  = inc[DW:1];
      rsp_valid_in = st_ff[QW].valid;
      rsp_data_in.a_less_than_b  = st_ff[QW].lt;
      rsp_data_in.a_equals_b     = st_ff[QW].eq;
      rsp_data_in.divide_by_zero = st_ff[QW].dz;
      if (((st_ff[QW].action == q24alu_pkg::ACT_MUL) ||
           (st_ff[QW].action == q24alu_pkg::ACT_DIV)) && !st_ff[QW].dz) begin
         rsp_data_in.result = st_ff[QW].neg ? (~rnd + 1'b1) : rnd;
      end else begin
         rsp_data_in.result = st_ff[QW].simple;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ src/q24alu_checker.sv @@
module q24alu_checker #(
   parameter int FRAC_BITS = q24alu_pkg::FRAC_BITS_DEFAULT
) (
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input logic                rsp_valid,
   input q24alu_pkg::rsp_type rsp_data
);

   localparam int LAT = FRAC_BITS + 35;

   // a response only follows a transaction issued a fixed latency earlier
   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LAT))
      else $error("response without a matching transaction");

   // the pipeline never stalls the request side
   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   // divide by zero returns zero
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.divide_by_zero) |-> (rsp_data.result == '0))
      else $error("nonzero result on divide by zero");

   // compare flags are exclusive
   a_cmp_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.a_less_than_b && rsp_data.a_equals_b))
      else $error("less and equal both set");

   // no response in the cycle after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response right after reset");

endmodule

bind q24_8_fixed_point_alu q24alu_checker #(.FRAC_BITS(FRAC_BITS)) u_checker (.*);

@@ tb/sv/tb.sv @@
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC = 8;
   localparam int LATENCY = FRAC + 34;
   localparam int STALL_LIMIT = 2000;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   q24alu_pkg::req_type req_data;
   logic                rsp_valid;
   q24alu_pkg::rsp_type rsp_data;

   q24alu_pkg::rsp_type pending_results[$];
   int      fail_count;
   int      quiet_cycles;
   bit      gaps_on;

   q24_8_fixed_point_alu #(.FRAC_BITS(FRAC)) DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // halve with the remainder folded back in, rounding halves away from zero
   function automatic longint halve_away(longint v);
      return v / 2 + v % 2;
   endfunction

   // compute the expected response of one transaction
   function automatic q24alu_pkg::rsp_type alu_result(q24alu_pkg::req_type r);
      q24alu_pkg::rsp_type o;
      longint  a;
      longint  b;
      longint  q;
      a = r.operand_a;
      b = r.operand_b;
      o = '0;
      case (r.action)
         q24alu_pkg::ACT_ADD:    o.result = 32'(a + b);
         q24alu_pkg::ACT_SUB:    o.result = 32'(a - b);
         q24alu_pkg::ACT_MUL: begin
            q = (a * b) / (longint'(1) << (FRAC - 1));
            o.result = 32'(halve_away(q));
         end
         q24alu_pkg::ACT_DIV: begin
            if (b == 0) begin
               o.divide_by_zero = 1'b1;
            end else begin
               q = (a * (longint'(1) << (FRAC + 1))) / b;
               o.result = 32'(halve_away(q));
            end
         end
         q24alu_pkg::ACT_NEGATE: o.result = 32'(-a);
         default:                o.result = '0;
      endcase
      o.a_less_than_b = a < b;
      o.a_equals_b    = a == b;
      return o;
   endfunction

   // issue one transaction, with a random gap before it while gaps_on is set
   task automatic send_op(logic [2:0] act, logic [31:0] a, logic [31:0] b);
      q24alu_pkg::req_type r;
      r.action = act;
      r.operand_a = a;
      r.operand_b = b;
      while (gaps_on && $urandom_range(99) < 28) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_results.push_back(alu_result(r));
   endtask

   function automatic logic [31:0] rand_operand();
      case ($urandom_range(5))
         0: return 32'($urandom_range(1023)) - 32'd512;
         1: return {$urandom_range(1) ? 8'hff : 8'h00, 24'($urandom)};
         2: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
         3: return 32'd0;
         default: return $urandom;
      endcase
   endfunction

   // check each response against the oldest expectation
   always @(posedge clock) begin
      q24alu_pkg::rsp_type e;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $error("response with no transaction outstanding");
            fail_count++;
         end else begin
            e = pending_results.pop_front();
            if (rsp_data.result !== e.result) begin
               $error("result exp %h got %h", e.result, rsp_data.result);
               fail_count++;
            end
            if (rsp_data.a_less_than_b !== e.a_less_than_b) begin
               $error("a_less_than_b exp %b got %b", e.a_less_than_b,
                      rsp_data.a_less_than_b);
               fail_count++;
            end
            if (rsp_data.a_equals_b !== e.a_equals_b) begin
               $error("a_equals_b exp %b got %b", e.a_equals_b, rsp_data.a_equals_b);
               fail_count++;
            end
            if (rsp_data.divide_by_zero !== e.divide_by_zero) begin
               $error("divide_by_zero exp %b got %b", e.divide_by_zero,
                      rsp_data.divide_by_zero);
               fail_count++;
            end
         end
      end
   end

   // end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   task automatic test_extremes();
      logic [31:0] edges[6];
      edges = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff, 32'h100,
                32'hffff_ff00};
      for (int op = 0; op < 8; op++) begin
         send_op(3'(op), edges[$urandom_range(5)], edges[$urandom_range(5)]);
      end
      send_op(q24alu_pkg::ACT_DIV, 32'h0000_0300, 32'h0);
      send_op(q24alu_pkg::ACT_DIV, 32'h8000_0000, 32'hffff_ffff);
      send_op(q24alu_pkg::ACT_NEGATE, 32'h8000_0000, 32'h5);
      send_op(q24alu_pkg::ACT_MUL, 32'h7fff_ffff, 32'h7fff_ffff);
      send_op(q24alu_pkg::ACT_MUL, 32'h8000_0000, 32'h8000_0000);
      send_op(q24alu_pkg::ACT_MUL, 32'h0000_0001, 32'h0000_0080);
      send_op(q24alu_pkg::ACT_MUL, 32'hffff_ffff, 32'h0000_0080);
      send_op(q24alu_pkg::ACT_DIV, 32'h0000_0001, 32'h0000_0200);
      send_op(q24alu_pkg::ACT_DIV, 32'hffff_ffff, 32'h0000_0200);
      send_op(q24alu_pkg::ACT_ADD, 32'h7fff_ffff, 32'h1);
      send_op(q24alu_pkg::ACT_SUB, 32'h8000_0000, 32'h1);
      send_op(q24alu_pkg::ACT_SUB, 32'h1234_5678, 32'h1234_5678);
   endtask

   task automatic test_random(int count);
      logic [2:0] act;
      for (int i = 0; i < count; i++) begin
         gaps_on = !(i >= count / 3 && i < count / 3 + 200);
         act = $urandom_range(15) == 0 ? 3'($urandom_range(7, 5))
                                       : 3'($urandom_range(4));
         send_op(act, rand_operand(), $urandom_range(7) == 0 ? 32'd0 : rand_operand());
      end
      gaps_on = 1'b1;
   endtask

   initial begin
      int drain;
      start = 1'b0;
      req_data = '0;
      reset = 1'b1;
      fail_count = 0;
      quiet_cycles = 0;
      gaps_on = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_extremes();
      test_random(1430);
      start <= 1'b0;
      drain = 0;
      while (pending_results.size() != 0 && drain < 20 * LATENCY) begin
         @(posedge clock);
         drain++;
      end
      repeat (LATENCY + 4) @(posedge clock);
      if (fail_count == 0 && pending_results.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end
endmodule

@@ sim.f @@
src/q24alu_pkg.sv
src/q24_8_fixed_point_alu.sv
src/q24alu_checker.sv
tb/sv/tb.sv
